// ===== hdl/vlan_table_and_tag_strip_top_defines.svh =====
// assertion macros for the vlan table and tag strip block
`ifndef VLAN_TABLE_AND_TAG_STRIP_TOP_DEFINES_SVH
`define VLAN_TABLE_AND_TAG_STRIP_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define VTTS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define VTTS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vtts_pkg.sv =====
// shared constants and types of the vlan table and tag strip block
`default_nettype none

package vtts_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int PORT_COUNT    = 8;

  localparam int ACTION_W = 2;
  localparam int PORT_W   = 3;
  localparam int VID_W    = 12;
  localparam int SLOT_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  // frame head layout
  localparam int HEAD_LEN  = 18;
  localparam int TAG_POS   = 12;
  localparam int TAG_LEN   = 4;
  localparam int VID_HI    = 14;
  localparam int VID_LO    = 15;
  localparam int HEAD_AW   = $clog2(HEAD_LEN);
  localparam int BIDX_W    = $clog2(HEAD_LEN + 1);
  localparam int DUMP_LEN  = HEAD_LEN - TAG_LEN;
  localparam int DUMP_W    = $clog2(DUMP_LEN);
  localparam logic [DUMP_W-1:0] DUMP_LAST = DUMP_W'(DUMP_LEN - 1);

  localparam logic [VID_W-1:0] VID_RESERVED = 12'hFFF;

  localparam logic [ACTION_W-1:0] ACT_CREATE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DESTROY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADMIN   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RX      = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSPACE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLAIMED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNCLAIMED = 3'd5;

  typedef enum logic [1:0] {
    TBL_NOP,
    TBL_CREATE,
    TBL_CLEAR,
    TBL_ADMIN
  } tbl_op_e;

  // one index serves read, compare and write
  typedef struct packed {
    tbl_op_e            op;
    logic [IDX_W-1:0]   idx;
    logic [PORT_W-1:0]  key_port;
    logic [VID_W-1:0]   key_vid;
    logic               wr_admin;
  } tbl_req_t;

  typedef struct packed {
    logic used;
    logic admin;
    logic hit;
  } tbl_rsp_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [BYTE_W-1:0]   byte_out;
    logic                byte_valid;
    logic                frame_end;
  } beat_t;

  function automatic beat_t mgmt_beat(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl);
    beat_t b;
    b            = '0;
    b.status     = st;
    b.slot_out   = sl;
    return b;
  endfunction

  function automatic beat_t unclaimed_beat();
    beat_t b;
    b           = '0;
    b.status    = ST_UNCLAIMED;
    b.frame_end = 1'b1;
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/vtts_if.sv =====
// input and output channel interfaces of the vlan table and tag strip block
`default_nettype none

interface vtts_in_if import vtts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PORT_W-1:0]   port;
  logic [VID_W-1:0]    vid;
  logic [SLOT_W-1:0]   slot;
  logic                admin_up;
  logic [BYTE_W-1:0]   data_byte;
  logic                last_byte;

  modport source (output valid, action, port, vid, slot, admin_up, data_byte, last_byte,
                  input ready);
  modport sink (input valid, action, port, vid, slot, admin_up, data_byte, last_byte,
                output ready);
endinterface

interface vtts_out_if import vtts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [BYTE_W-1:0]   byte_out;
  logic                byte_valid;
  logic                frame_end;

  modport source (output valid, status, slot_out, byte_out, byte_valid, frame_end,
                  input ready);
  modport sink (input valid, status, slot_out, byte_out, byte_valid, frame_end,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/vtts_table.sv =====
// vlan entry table with one shared entry compare unit
`default_nettype none

module vtts_table import vtts_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tbl_req_t req_i,
  output tbl_rsp_t      rsp_o
);

  logic              used_q  [TABLE_ENTRIES];
  logic [PORT_W-1:0] port_q  [TABLE_ENTRIES];
  logic [VID_W-1:0]  vid_q   [TABLE_ENTRIES];
  logic              admin_q [TABLE_ENTRIES];

  logic in_range;

  assign in_range = int'(req_i.idx) < TABLE_ENTRIES;

  // shared compare unit
  always_comb begin
    rsp_o = '0;
    if (in_range) begin
      rsp_o.used  = used_q[req_i.idx];
      rsp_o.admin = admin_q[req_i.idx];
      rsp_o.hit   = used_q[req_i.idx] && (port_q[req_i.idx] == req_i.key_port) &&
                    (vid_q[req_i.idx] == req_i.key_vid);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        used_q[i]  <= 1'b0;
        port_q[i]  <= '0;
        vid_q[i]   <= '0;
        admin_q[i] <= 1'b0;
      end
    end else if (in_range) begin
      unique case (req_i.op)
        TBL_CREATE: begin
          used_q[req_i.idx]  <= 1'b1;
          port_q[req_i.idx]  <= req_i.key_port;
          vid_q[req_i.idx]   <= req_i.key_vid;
          admin_q[req_i.idx] <= 1'b0;
        end
        TBL_CLEAR: begin
          used_q[req_i.idx]  <= 1'b0;
          port_q[req_i.idx]  <= '0;
          vid_q[req_i.idx]   <= '0;
          admin_q[req_i.idx] <= 1'b0;
        end
        TBL_ADMIN: begin
          admin_q[req_i.idx] <= req_i.wr_admin;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vlan_table_and_tag_strip_top.sv =====
// top level of the vlan table and 802.1q receive tag strip block
//
//   channel  dir  handshake     contents
//   in_i     in   valid/ready   action, port, vid, slot, admin_up, data_byte, last_byte
//   out_o    out  valid/ready   status, slot_out, byte_out, byte_valid, frame_end
//
// one item at a time; a table scan steps one entry per cycle through the shared compare unit
// create: rejected at once on a bad vid or port, else a duplicate scan, then a free-entry scan
// destroy, set admin and a byte with a result each give one result beat; a byte without result none
// byte 18: a lookup scan of the table, then, when claimed, 14 beats drained one per cycle
// while out_o keeps taking them, or one not-claimed beat when it also ends the frame
// reset clears the table and the frame state at once, no sweep; a stalled out_o holds
// the output register and the sequencer waits on it while in_i stays not ready
`default_nettype none

`include "vlan_table_and_tag_strip_top_defines.svh"

module vlan_table_and_tag_strip_top import vtts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vtts_in_if.sink   in_i,
  vtts_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUP,
    S_FREE,
    S_LOOKUP,
    S_DUMP,
    S_RESULT
  } state_e;

  state_e              state_q, state_d;
  logic [PORT_W-1:0]   port_q, port_d;
  logic [VID_W-1:0]    vid_q, vid_d;
  logic                last_q, last_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [DUMP_W-1:0]   dump_q, dump_d;
  logic [BIDX_W-1:0]   byte_idx_q, byte_idx_d;
  logic                claimed_q, claimed_d;
  logic [IDX_W-1:0]    cslot_q, cslot_d;
  logic [VID_W-1:0]    fvid_q, fvid_d;
  beat_t               res_q, res_d;
  logic                out_valid_q, out_valid_d;
  beat_t               out_beat_q, out_beat_d;

  logic [BYTE_W-1:0]   head_q [HEAD_LEN];
  logic                head_we;
  logic [HEAD_AW-1:0]  head_ra;

  tbl_req_t            tbl_req;
  tbl_rsp_t            tbl_rsp;

  logic                in_acc;
  logic                out_free;
  logic                push;
  beat_t               push_beat;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  // output register takes a new beat when empty or being drained
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_beat_q.status;
  assign out_o.slot_out   = out_beat_q.slot_out;
  assign out_o.byte_out   = out_beat_q.byte_out;
  assign out_o.byte_valid = out_beat_q.byte_valid;
  assign out_o.frame_end  = out_beat_q.frame_end;

  // stripped frame order: bytes 0..11 then 16..17
  assign head_ra = (int'(dump_q) < TAG_POS) ? HEAD_AW'(dump_q)
                                             : HEAD_AW'(dump_q) + HEAD_AW'(TAG_LEN);

  vtts_table u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (tbl_req),
    .rsp_o (tbl_rsp)
  );

  always_comb begin
    state_d    = state_q;
    port_d     = port_q;
    vid_d      = vid_q;
    last_d     = last_q;
    idx_d      = idx_q;
    dump_d     = dump_q;
    byte_idx_d = byte_idx_q;
    claimed_d  = claimed_q;
    cslot_d    = cslot_q;
    fvid_d     = fvid_q;
    res_d      = res_q;
    head_we    = 1'b0;
    push       = 1'b0;
    push_beat  = res_q;

    tbl_req          = '0;
    tbl_req.op       = TBL_NOP;
    tbl_req.idx      = idx_q;
    tbl_req.key_port = port_q;
    tbl_req.key_vid  = vid_q;
    tbl_req.wr_admin = in_i.admin_up;

    unique case (state_q)
      S_IDLE: begin
        // destroy and set admin address the table by the item's slot
        tbl_req.idx = IDX_W'(in_i.slot);
        if (in_acc) begin
          port_d = in_i.port;
          vid_d  = in_i.vid;
          last_d = in_i.last_byte;
          idx_d  = '0;
          unique case (in_i.action)
            ACT_CREATE: begin
              if ((in_i.vid == '0) || (in_i.vid >= VID_RESERVED) ||
                  (int'(in_i.port) >= PORT_COUNT)) begin
                res_d   = mgmt_beat(ST_INVALID, '0);
                state_d = S_RESULT;
              end else begin
                state_d = S_DUP;
              end
            end
            ACT_DESTROY: begin
              if (int'(in_i.slot) >= TABLE_ENTRIES) begin
                res_d = mgmt_beat(ST_INVALID, in_i.slot);
              end else begin
                tbl_req.op = TBL_CLEAR;
                res_d      = mgmt_beat(ST_OK, in_i.slot);
              end
              state_d = S_RESULT;
            end
            ACT_ADMIN: begin
              if ((int'(in_i.slot) >= TABLE_ENTRIES) || !tbl_rsp.used) begin
                res_d = mgmt_beat(ST_INVALID, in_i.slot);
              end else begin
                tbl_req.op = TBL_ADMIN;
                res_d      = mgmt_beat(ST_OK, in_i.slot);
              end
              state_d = S_RESULT;
            end
            ACT_RX: begin
              if (int'(byte_idx_q) < HEAD_LEN) begin
                head_we    = 1'b1;
                byte_idx_d = byte_idx_q + 1'b1;
                if (int'(byte_idx_q) == VID_HI) begin
                  fvid_d[VID_W-1:BYTE_W] = in_i.data_byte[VID_W-BYTE_W-1:0];
                end
                if (int'(byte_idx_q) == VID_LO) begin
                  fvid_d[BYTE_W-1:0] = in_i.data_byte;
                end
                if (int'(byte_idx_q) == HEAD_LEN - 1) begin
                  state_d = S_LOOKUP;
                end else if (in_i.last_byte) begin
                  // short frame
                  res_d      = unclaimed_beat();
                  byte_idx_d = '0;
                  claimed_d  = 1'b0;
                  cslot_d    = '0;
                  state_d    = S_RESULT;
                end
              end else begin
                if (claimed_q) begin
                  res_d            = '0;
                  res_d.status     = ST_CLAIMED;
                  res_d.slot_out   = SLOT_W'(cslot_q);
                  res_d.byte_out   = in_i.data_byte;
                  res_d.byte_valid = 1'b1;
                  res_d.frame_end  = in_i.last_byte;
                  state_d          = S_RESULT;
                end else if (in_i.last_byte) begin
                  res_d   = unclaimed_beat();
                  state_d = S_RESULT;
                end
                if (in_i.last_byte) begin
                  byte_idx_d = '0;
                  claimed_d  = 1'b0;
                  cslot_d    = '0;
                end
              end
            end
          endcase
        end
      end

      S_DUP: begin
        if (tbl_rsp.hit) begin
          res_d   = mgmt_beat(ST_EXISTS, SLOT_W'(idx_q));
          state_d = S_RESULT;
        end else if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          state_d = S_FREE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_FREE: begin
        if (!tbl_rsp.used) begin
          tbl_req.op = TBL_CREATE;
          res_d      = mgmt_beat(ST_OK, SLOT_W'(idx_q));
          state_d    = S_RESULT;
        end else if (idx_q == IDX_LAST) begin
          res_d   = mgmt_beat(ST_NOSPACE, '0);
          state_d = S_RESULT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_LOOKUP: begin
        // first used entry with this port and vid decides, admin state checked after
        tbl_req.key_vid = fvid_q;
        if (tbl_rsp.hit && tbl_rsp.admin) begin
          claimed_d = 1'b1;
          cslot_d   = idx_q;
          dump_d    = '0;
          state_d   = S_DUMP;
        end else if (tbl_rsp.hit || (idx_q == IDX_LAST)) begin
          if (last_q) begin
            res_d      = unclaimed_beat();
            byte_idx_d = '0;
            claimed_d  = 1'b0;
            cslot_d    = '0;
            state_d    = S_RESULT;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_DUMP: begin
        if (out_free) begin
          push                 = 1'b1;
          push_beat            = '0;
          push_beat.status     = ST_CLAIMED;
          push_beat.slot_out   = SLOT_W'(cslot_q);
          push_beat.byte_out   = head_q[head_ra];
          push_beat.byte_valid = 1'b1;
          push_beat.frame_end  = (dump_q == DUMP_LAST) && last_q;
          if (dump_q == DUMP_LAST) begin
            if (last_q) begin
              byte_idx_d = '0;
              claimed_d  = 1'b0;
              cslot_d    = '0;
            end
            state_d = S_IDLE;
          end else begin
            dump_d = dump_q + 1'b1;
          end
        end
      end

      S_RESULT: begin
        if (out_free) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q && !out_o.ready;
    out_beat_d  = out_beat_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_beat_d  = push_beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      dump_q      <= '0;
      byte_idx_q  <= '0;
      claimed_q   <= 1'b0;
      cslot_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      dump_q      <= dump_d;
      byte_idx_q  <= byte_idx_d;
      claimed_q   <= claimed_d;
      cslot_q     <= cslot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    port_q     <= port_d;
    vid_q      <= vid_d;
    last_q     <= last_d;
    fvid_q     <= fvid_d;
    res_q      <= res_d;
    out_beat_q <= out_beat_d;
  end

  // frame head buffer
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_q[byte_idx_q[HEAD_AW-1:0]] <= in_i.data_byte;
    end
  end

  // a frame is only claimed once its whole head is in
  `VTTS_ASSERT_IMP(a_claim_after_head, claimed_q, byte_idx_q == BIDX_W'(HEAD_LEN), "early claim")

  // management items always make the sequencer busy right after they are taken
  `VTTS_ASSERT_NXT(a_mgmt_busy, in_acc && (in_i.action != ACT_RX), !in_i.ready, "not busy")

  // the drain runs only for a claimed frame and stays inside the stripped head
  `VTTS_ASSERT_IMP(a_dump_claimed, state_q == S_DUMP, claimed_q && (dump_q <= DUMP_LAST), "bad drain")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench of the vlan table and tag strip block
`timescale 1ns / 1ps

module testbench import vtts_pkg::*; ();

  // one command on the input channel
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PORT_W-1:0]   port;
    logic [VID_W-1:0]    vid;
    logic [SLOT_W-1:0]   slot;
    logic                admin_up;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_byte;
  } vtts_cmd_t;

  // quiet cycles before the run is given up
  localparam int QUIET_LIMIT = 4000;
  // cycles to watch for stray beats once everything has come back
  localparam int TAIL_CYCLES = 2 * TABLE_ENTRIES + 24;

  logic clk_i = 1'b0;
  logic rst_ni;

  vtts_in_if  in_ch ();
  vtts_out_if out_ch ();

  vlan_table_and_tag_strip_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #6 clk_i = ~clk_i;

  // stimulus and checking state
  vtts_cmd_t pending_cmds[$];
  vtts_cmd_t cmd_on_bus;
  beat_t     expected_beats[$];
  int        mismatch_count = 0;
  int        cmds_planned   = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;

  // own copy of the vlan table and the frame head
  logic              vlan_used[TABLE_ENTRIES];
  logic [PORT_W-1:0] vlan_port[TABLE_ENTRIES];
  logic [VID_W-1:0]  vlan_vid[TABLE_ENTRIES];
  logic              vlan_up[TABLE_ENTRIES];
  logic [BYTE_W-1:0] head_bytes[HEAD_LEN];
  int                head_count;
  logic              rx_owned;
  logic [SLOT_W-1:0] rx_slot;

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      vlan_used[i] = 1'b0;
      vlan_port[i] = '0;
      vlan_vid[i]  = '0;
      vlan_up[i]   = 1'b0;
    end
    head_count = 0;
    rx_owned   = 1'b0;
    rx_slot    = '0;
  end

  // ---------------------------------------------------------------------------
  // prediction: apply one accepted command to the table copy and queue the beats
  // ---------------------------------------------------------------------------

  function automatic beat_t make_beat(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
                                      logic [BYTE_W-1:0] b, logic bv, logic fe);
    beat_t r;
    r.status     = st;
    r.slot_out   = sl;
    r.byte_out   = b;
    r.byte_valid = bv;
    r.frame_end  = fe;
    return r;
  endfunction

  // first used entry with this port and vid, -1 when none
  function automatic int find_entry(logic [PORT_W-1:0] p, logic [VID_W-1:0] v);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (vlan_used[i] && vlan_port[i] == p && vlan_vid[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic void predict_cmd(vtts_cmd_t c);
    int                hit;
    logic [VID_W-1:0]  fv;
    case (c.action)
      ACT_CREATE: begin
        if (c.vid == '0 || c.vid >= VID_RESERVED || int'(c.port) >= PORT_COUNT) begin
          expected_beats.push_back(make_beat(ST_INVALID, '0, '0, 1'b0, 1'b0));
        end else begin
          hit = find_entry(c.port, c.vid);
          if (hit >= 0) begin
            expected_beats.push_back(make_beat(ST_EXISTS, SLOT_W'(hit), '0, 1'b0, 1'b0));
          end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (hit < 0 && !vlan_used[i]) hit = i;
            end
            if (hit < 0) begin
              expected_beats.push_back(make_beat(ST_NOSPACE, '0, '0, 1'b0, 1'b0));
            end else begin
              // new entries come up admin down
              vlan_used[hit] = 1'b1;
              vlan_port[hit] = c.port;
              vlan_vid[hit]  = c.vid;
              vlan_up[hit]   = 1'b0;
              expected_beats.push_back(make_beat(ST_OK, SLOT_W'(hit), '0, 1'b0, 1'b0));
            end
          end
        end
      end
      ACT_DESTROY: begin
        if (int'(c.slot) >= TABLE_ENTRIES) begin
          expected_beats.push_back(make_beat(ST_INVALID, c.slot, '0, 1'b0, 1'b0));
        end else begin
          // cleared even when it was never used
          vlan_used[c.slot] = 1'b0;
          vlan_port[c.slot] = '0;
          vlan_vid[c.slot]  = '0;
          vlan_up[c.slot]   = 1'b0;
          expected_beats.push_back(make_beat(ST_OK, c.slot, '0, 1'b0, 1'b0));
        end
      end
      ACT_ADMIN: begin
        if (int'(c.slot) >= TABLE_ENTRIES || !vlan_used[c.slot]) begin
          expected_beats.push_back(make_beat(ST_INVALID, c.slot, '0, 1'b0, 1'b0));
        end else begin
          vlan_up[c.slot] = c.admin_up;
          expected_beats.push_back(make_beat(ST_OK, c.slot, '0, 1'b0, 1'b0));
        end
      end
      default: begin
        if (head_count < HEAD_LEN) begin
          head_bytes[head_count] = c.data_byte;
          head_count++;
          if (head_count == HEAD_LEN) begin
            // vid sits in the low nibble of byte 14 and all of byte 15
            fv  = {head_bytes[VID_HI][3:0], head_bytes[VID_LO]};
            hit = find_entry(c.port, fv);
            if (hit >= 0 && vlan_up[hit]) begin
              rx_owned = 1'b1;
              rx_slot  = SLOT_W'(hit);
              // head out without the four tag bytes
              for (int k = 0; k < HEAD_LEN; k++) begin
                if (k < TAG_POS || k >= TAG_POS + TAG_LEN) begin
                  expected_beats.push_back(make_beat(ST_CLAIMED, rx_slot, head_bytes[k],
                                                     1'b1,
                                                     (k == HEAD_LEN - 1) && c.last_byte));
                end
              end
            end
          end
        end else if (rx_owned) begin
          expected_beats.push_back(make_beat(ST_CLAIMED, rx_slot, c.data_byte, 1'b1,
                                             c.last_byte));
        end
        if (c.last_byte) begin
          if (!rx_owned) begin
            expected_beats.push_back(make_beat(ST_UNCLAIMED, '0, '0, 1'b0, 1'b1));
          end
          head_count = 0;
          rx_owned   = 1'b0;
          rx_slot    = '0;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one command per handshake, held until taken
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.action    <= '0;
      in_ch.port      <= '0;
      in_ch.vid       <= '0;
      in_ch.slot      <= '0;
      in_ch.admin_up  <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.last_byte <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // the command on the bus was just taken
      if (in_ch.valid) predict_cmd(cmd_on_bus);
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_on_bus       = pending_cmds.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.action    <= cmd_on_bus.action;
        in_ch.port      <= cmd_on_bus.port;
        in_ch.vid       <= cmd_on_bus.vid;
        in_ch.slot      <= cmd_on_bus.slot;
        in_ch.admin_up  <= cmd_on_bus.admin_up;
        in_ch.data_byte <= cmd_on_bus.data_byte;
        in_ch.last_byte <= cmd_on_bus.last_byte;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each result beat with the oldest expectation
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: status %0d slot %0d byte %0d", out_ch.status,
                 out_ch.slot_out, out_ch.byte_out);
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("status", 8'(want.status), 8'(out_ch.status));
          check_field("slot_out", 8'(want.slot_out), 8'(out_ch.slot_out));
          check_field("byte_out", want.byte_out, out_ch.byte_out);
          check_field("byte_valid", 8'(want.byte_valid), 8'(out_ch.byte_valid));
          check_field("frame_end", 8'(want.frame_end), 8'(out_ch.frame_end));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    int quiet_cycles;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // command builders
  // ---------------------------------------------------------------------------

  // every field random, so the fields a command ignores still toggle
  function automatic vtts_cmd_t random_cmd();
    vtts_cmd_t c;
    c.action    = ACTION_W'($urandom_range(3));
    c.port      = PORT_W'($urandom_range(7));
    c.vid       = VID_W'($urandom());
    c.slot      = SLOT_W'($urandom_range(7));
    c.admin_up  = 1'($urandom_range(1));
    c.data_byte = BYTE_W'($urandom());
    c.last_byte = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic add_mgmt(logic [ACTION_W-1:0] act, logic [PORT_W-1:0] p,
                          logic [VID_W-1:0] v, logic [SLOT_W-1:0] s, logic up);
    vtts_cmd_t c;
    c          = random_cmd();
    c.action   = act;
    c.port     = p;
    c.vid      = v;
    c.slot     = s;
    c.admin_up = up;
    pending_cmds.push_back(c);
    cmds_planned++;
  endtask

  // management noise: bad vids, duplicates, destroys and admin flips
  task automatic add_random_mgmt();
    int                pick;
    logic [VID_W-1:0]  v;
    logic [PORT_W-1:0] p;
    p = PORT_W'($urandom_range(7));
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = VID_RESERVED;
      2: begin
        // retry a pair that is in the table now, mostly gives exists
        pick = $urandom_range(TABLE_ENTRIES - 1);
        v    = vlan_used[pick] ? vlan_vid[pick] : VID_W'($urandom_range(1, 4094));
        p    = vlan_used[pick] ? vlan_port[pick] : p;
      end
      default: v = VID_W'($urandom_range(1, 4094));
    endcase
    case ($urandom_range(2))
      0:       add_mgmt(ACT_CREATE, p, v, SLOT_W'($urandom_range(7)), 1'($urandom_range(1)));
      1:       add_mgmt(ACT_DESTROY, p, v, SLOT_W'($urandom_range(7)), 1'($urandom_range(1)));
      default: add_mgmt(ACT_ADMIN, p, v, SLOT_W'($urandom_range(7)), 1'($urandom_range(1)));
    endcase
  endtask

  // tagged frame of len bytes looked up on port p with vid v,
  // with management commands slipped in between bytes now and then
  task automatic add_frame(logic [PORT_W-1:0] p, logic [VID_W-1:0] v, int len);
    vtts_cmd_t c;
    for (int k = 0; k < len; k++) begin
      c           = random_cmd();
      c.action    = ACT_RX;
      c.last_byte = (k == len - 1);
      // the port only counts on the decision byte
      if (k == HEAD_LEN - 1 || $urandom_range(9) < 8) c.port = p;
      if (k == VID_HI) c.data_byte = {4'($urandom_range(15)), v[11:8]};
      if (k == VID_LO) c.data_byte = v[7:0];
      pending_cmds.push_back(c);
      cmds_planned++;
      if (k != len - 1 && $urandom_range(99) < 6) add_random_mgmt();
    end
  endtask

  // pause the sender until everything sent has come back
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_ch.valid || expected_beats.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // one burst of random traffic, shaped from the table as it stands when idle
  task automatic plan_burst();
    int used_slots[$];
    int r;
    int len;
    int s;
    logic [PORT_W-1:0] p;
    logic [VID_W-1:0]  v;
    wait_drained();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (vlan_used[i]) used_slots.push_back(i);
    end
    // keep the table populated so frames have something to match
    if (used_slots.size() < 4) begin
      repeat (2) add_mgmt(ACT_CREATE, PORT_W'($urandom_range(7)),
                          VID_W'($urandom_range(1, 4094)), SLOT_W'($urandom_range(7)),
                          1'($urandom_range(1)));
    end
    // bring most entries up, take a few down
    foreach (used_slots[j]) begin
      s = used_slots[j];
      if (!vlan_up[s] && $urandom_range(9) < 7) begin
        add_mgmt(ACT_ADMIN, PORT_W'($urandom_range(7)), VID_W'($urandom()), SLOT_W'(s), 1'b1);
      end else if (vlan_up[s] && $urandom_range(9) == 0) begin
        add_mgmt(ACT_ADMIN, PORT_W'($urandom_range(7)), VID_W'($urandom()), SLOT_W'(s), 1'b0);
      end
    end
    repeat ($urandom_range(2, 4)) begin
      if (used_slots.size() != 0 && $urandom_range(99) < 75) begin
        s = used_slots[$urandom_range(used_slots.size() - 1)];
        p = vlan_port[s];
        v = vlan_vid[s];
      end else begin
        p = PORT_W'($urandom_range(7));
        v = VID_W'($urandom());
      end
      // short frames, frames ending on the decision byte, longer frames
      r = $urandom_range(99);
      if (r < 15)      len = $urandom_range(1, HEAD_LEN - 1);
      else if (r < 35) len = HEAD_LEN;
      else             len = $urandom_range(HEAD_LEN + 1, HEAD_LEN + 8);
      add_frame(p, v, len);
    end
    if ($urandom_range(3) == 0) add_random_mgmt();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    // the driver and monitor set their outputs while reset is low
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // phase one: sender rarely idle, receiver often stalls
    send_idle_pct = 18;
    recv_idle_pct = 60;

    // directed: vid zero and the reserved vid are refused
    add_mgmt(ACT_CREATE, 3'd0, 12'h000, 3'd0, 1'b0);
    add_mgmt(ACT_CREATE, 3'd7, VID_RESERVED, 3'd7, 1'b1);
    // highest legal vid, lowest legal vid, then a duplicate
    add_mgmt(ACT_CREATE, 3'd7, 12'hFFE, 3'd0, 1'b0);
    add_mgmt(ACT_CREATE, 3'd0, 12'h001, 3'd0, 1'b0);
    add_mgmt(ACT_CREATE, 3'd0, 12'h001, 3'd5, 1'b1);
    // admin on an unused entry is refused, then slots 0 and 1 are brought up
    add_mgmt(ACT_ADMIN, 3'd0, 12'h000, 3'd5, 1'b1);
    add_mgmt(ACT_ADMIN, 3'd0, 12'h000, 3'd0, 1'b1);
    add_mgmt(ACT_ADMIN, 3'd0, 12'h000, 3'd1, 1'b1);
    // same vid on another port is a new entry; fill the table
    add_mgmt(ACT_CREATE, 3'd3, 12'h001, 3'd0, 1'b0);
    add_mgmt(ACT_CREATE, 3'd5, 12'h800, 3'd0, 1'b0);
    add_mgmt(ACT_CREATE, 3'd2, 12'h7FF, 3'd0, 1'b0);
    add_mgmt(ACT_CREATE, 3'd6, 12'hAAA, 3'd0, 1'b0);
    add_mgmt(ACT_CREATE, 3'd1, 12'h555, 3'd0, 1'b0);
    add_mgmt(ACT_CREATE, 3'd4, 12'h0F0, 3'd0, 1'b0);
    // table full
    add_mgmt(ACT_CREATE, 3'd7, 12'h00F, 3'd0, 1'b0);
    // destroy the last slot twice, then admin on it is refused
    add_mgmt(ACT_DESTROY, 3'd0, 12'h000, 3'd7, 1'b0);
    add_mgmt(ACT_DESTROY, 3'd0, 12'h000, 3'd7, 1'b0);
    add_mgmt(ACT_ADMIN, 3'd0, 12'h000, 3'd7, 1'b1);
    // admin down and up again
    add_mgmt(ACT_ADMIN, 3'd0, 12'h000, 3'd0, 1'b0);
    add_mgmt(ACT_ADMIN, 3'd0, 12'h000, 3'd0, 1'b1);
    // one-byte frame is never claimed
    add_frame(3'd0, 12'h001, 1);

    while (cmds_planned < 90) plan_burst();

    // phase two: sender often idle, receiver rarely stalls
    wait_drained();
    send_idle_pct = 60;
    recv_idle_pct = 18;
    while (cmds_planned < 170) plan_burst();

    // phase three: full rate on both sides
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (cmds_planned < 250) plan_burst();

    // let everything come back, then watch for stray beats
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
